// File: rtl/edgb_pkg.sv
// ----------------------------------------------------------------------------
// edgb_pkg
// Shared constants and types of the edge degree grid binner.
// ----------------------------------------------------------------------------
package edgb_pkg;

	localparam int VERTEX_BITS_DEF = 16;
	localparam int DEGREE_BITS_DEF = 32;
	localparam int WIDTH_BITS = 17;
	localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 17'd1024;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [3:0] {
		B_CLEAR,
		B_IDLE,
		B_START,
		B_DIV,
		B_RD_S,
		B_RD_D,
		B_WR_D,
		B_EMIT_F,
		B_EMIT_R
	} back_state_t;

	typedef enum logic [1:0] {
		SEL_SRC,
		SEL_DST,
		SEL_MAX
	} div_sel_t;

endpackage

// File: rtl/edgb_ram.sv
// ----------------------------------------------------------------------------
// edgb_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module edgb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/edgb_fifo.sv
// ----------------------------------------------------------------------------
// edgb_fifo
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
module edgb_fifo #(
	parameter int WIDTH = 49,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             empty,
	output logic             full
);
	localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PB-1:0] wptr_q, rptr_q;
	logic [PB:0] count_q;

	assign empty = (count_q == '0);
	assign full = (count_q == (PB+1)'(DEPTH));
	assign head = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PB'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PB'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_data;
		end
	end
endmodule

// File: rtl/edgb_div.sv
// ----------------------------------------------------------------------------
// edgb_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module edgb_div #(
	parameter int QB = 16,
	parameter int DB = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [QB-1:0] dividend,
	input  logic [DB-1:0] divisor,
	output logic          done,
	output logic [QB-1:0] quotient,
	output logic [DB-1:0] remainder
);
	localparam int CB = $clog2(QB + 1);

	logic [DB-1:0] rem_q, dvs_q;
	logic [QB-1:0] quo_q;
	logic [CB-1:0] cnt_q;
	logic          done_q;
	logic [DB:0]   trial;
	logic          ge;

	assign trial = {rem_q, quo_q[QB-1]};
	assign ge = (trial >= {1'b0, dvs_q});
	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CB'(QB);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				done_q <= (cnt_q == CB'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? DB'(trial - {1'b0, dvs_q}) : DB'(trial);
			quo_q <= {quo_q[QB-2:0], ge};
		end
	end
endmodule

// File: rtl/edgb_front.sv
// ----------------------------------------------------------------------------
// edgb_front
// Accepts edges, drops self-loops, tracks the running maximum vertex id.
// ----------------------------------------------------------------------------
module edgb_front #(
	parameter int VERTEX_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     edge_valid,
	output logic                     edge_stall,
	input  logic [VERTEX_BITS-1:0]   src_vertex,
	input  logic [VERTEX_BITS-1:0]   dst_vertex,
	input  logic                     queue_full,
	input  logic                     clr_busy,
	output logic                     push,
	output logic [3*VERTEX_BITS:0]   push_data
);
	logic [VERTEX_BITS-1:0] max_q, big;
	logic                   accept, rose;

	assign edge_stall = queue_full || clr_busy;
	assign accept = edge_valid && !edge_stall;
	assign big = (src_vertex > dst_vertex) ? src_vertex : dst_vertex;
	assign rose = big > max_q;
	assign push = accept && (src_vertex != dst_vertex);
	assign push_data = {rose, (rose ? big : max_q), dst_vertex, src_vertex};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
		end else if (push && rose) begin
			max_q <= big;
		end
	end
endmodule

// File: rtl/edgb_back.sv
// ----------------------------------------------------------------------------
// edgb_back
// Divides ids by the grid width, updates degrees, emits both binned edges.
// ----------------------------------------------------------------------------
module edgb_back #(
	parameter int VERTEX_BITS = 16,
	parameter int DEGREE_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [edgb_pkg::WIDTH_BITS-1:0]     eff_width,
	input  logic                                queue_empty,
	input  logic [3*VERTEX_BITS:0]              head,
	output logic                                pop,
	output logic                                clr_busy,
	output logic                                bin_valid,
	input  logic                                bin_stall,
	output logic [VERTEX_BITS-1:0]              cell_row,
	output logic [VERTEX_BITS-1:0]              cell_col,
	output logic [VERTEX_BITS-1:0]              local_first,
	output logic [VERTEX_BITS-1:0]              local_second,
	output logic [DEGREE_BITS-1:0]              first_degree,
	output logic [VERTEX_BITS-1:0]              highest_vertex,
	output logic [VERTEX_BITS:0]                cells_per_side,
	output logic                                last
);
	import edgb_pkg::*;

	localparam int VB = VERTEX_BITS;

	back_state_t st_q, st_d;
	div_sel_t    sel_q;

	logic [VB-1:0] s_q, d_q, m_q, qs_q, qd_q, rs_q, rd_q, clr_addr_q, operand;
	logic          rose_q;
	logic [VB:0]   count_q, cnt_new;
	logic [DEGREE_BITS-1:0] deg_s_q, deg_d_q, deg_inc;

	logic                  div_start, div_done;
	logic [VB-1:0]         div_quo;
	logic [WIDTH_BITS-1:0] div_rem;

	logic                  ram_we;
	logic [VB-1:0]         ram_waddr, ram_raddr;
	logic [DEGREE_BITS-1:0] ram_wdata, ram_rdata;

	logic out_valid_q, out_free;
	logic [VB-1:0] row_q, col_q, lf_q, ls_q, hv_q;
	logic [DEGREE_BITS-1:0] deg_out_q;
	logic [VB:0] cps_q;
	logic last_q;

	assign out_free = !out_valid_q || !bin_stall;
	assign clr_busy = (st_q == B_CLEAR);
	assign deg_inc = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
	assign cnt_new = (VB+1)'(div_quo) + 1'b1;

	always_comb begin
		case (sel_q)
			SEL_SRC: operand = s_q;
			SEL_DST: operand = d_q;
			default: operand = m_q;
		endcase
	end

	edgb_div #(.QB(VB), .DB(WIDTH_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(operand),
		.divisor(eff_width), .done(div_done), .quotient(div_quo),
		.remainder(div_rem)
	);

	edgb_ram #(.WIDTH(DEGREE_BITS), .DEPTH(2**VB)) u_deg (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	always_comb begin
		st_d = st_q;
		pop = 1'b0;
		div_start = 1'b0;
		ram_we = 1'b0;
		ram_waddr = s_q;
		ram_wdata = deg_inc;
		ram_raddr = s_q;
		case (st_q)
			B_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
				if (clr_addr_q == '1) st_d = B_IDLE;
			end
			B_IDLE: begin
				if (!queue_empty) begin
					pop = 1'b1;
					st_d = B_START;
				end
			end
			B_START: begin
				div_start = 1'b1;
				st_d = B_DIV;
			end
			B_DIV: begin
				if (div_done) begin
					if (sel_q == SEL_SRC || (sel_q == SEL_DST && rose_q)) begin
						st_d = B_START;
					end else begin
						st_d = B_RD_S;
					end
				end
			end
			B_RD_S: begin
				ram_raddr = s_q;
				st_d = B_RD_D;
			end
			B_RD_D: begin
				// data for src arrives, read dst in the same cycle
				ram_raddr = d_q;
				ram_we = 1'b1;
				ram_waddr = s_q;
				st_d = B_WR_D;
			end
			B_WR_D: begin
				ram_we = 1'b1;
				ram_waddr = d_q;
				st_d = B_EMIT_F;
			end
			B_EMIT_F: begin
				if (out_free) st_d = B_EMIT_R;
			end
			B_EMIT_R: begin
				if (out_free) st_d = B_IDLE;
			end
			default: st_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_CLEAR;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= SEL_SRC;
			clr_addr_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (st_q == B_CLEAR) clr_addr_q <= clr_addr_q + 1'b1;
			if (pop) sel_q <= SEL_SRC;
			if (st_q == B_DIV && div_done) begin
				case (sel_q)
					SEL_SRC: sel_q <= SEL_DST;
					SEL_DST: sel_q <= SEL_MAX;
					default: begin
						if (cnt_new > count_q) count_q <= cnt_new;
					end
				endcase
			end
			if ((st_q == B_EMIT_F || st_q == B_EMIT_R) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!bin_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			s_q <= head[VB-1:0];
			d_q <= head[2*VB-1:VB];
			m_q <= head[3*VB-1:2*VB];
			rose_q <= head[3*VB];
		end
		if (st_q == B_DIV && div_done) begin
			if (sel_q == SEL_SRC) begin
				qs_q <= div_quo;
				rs_q <= VB'(div_rem);
			end else if (sel_q == SEL_DST) begin
				qd_q <= div_quo;
				rd_q <= VB'(div_rem);
			end
		end
		if (st_q == B_RD_D) deg_s_q <= deg_inc;
		if (st_q == B_WR_D) deg_d_q <= deg_inc;
		if (st_q == B_EMIT_F && out_free) begin
			row_q <= qs_q;
			col_q <= qd_q;
			lf_q <= rs_q;
			ls_q <= rd_q;
			deg_out_q <= deg_s_q;
			hv_q <= m_q;
			cps_q <= count_q;
			last_q <= 1'b0;
		end else if (st_q == B_EMIT_R && out_free) begin
			row_q <= qd_q;
			col_q <= qs_q;
			lf_q <= rd_q;
			ls_q <= rs_q;
			deg_out_q <= deg_d_q;
			hv_q <= m_q;
			cps_q <= count_q;
			last_q <= 1'b1;
		end
	end

	assign bin_valid = out_valid_q;
	assign cell_row = row_q;
	assign cell_col = col_q;
	assign local_first = lf_q;
	assign local_second = ls_q;
	assign first_degree = deg_out_q;
	assign highest_vertex = hv_q;
	assign cells_per_side = cps_q;
	assign last = last_q;
endmodule

// File: rtl/edge_degree_grid_binner_top.sv
// ----------------------------------------------------------------------------
// edge_degree_grid_binner_top
// Bins graph edges into grid cells and keeps a saturating degree per vertex.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  edges   | edge_valid / edge_stall  | src_vertex, dst_vertex
//  bins    | bin_valid / bin_stall    | cell_row .. last, two per edge
//  width   | width_we                 | width_data
//
// in the back part an edge takes up to three serial divisions (one quotient
// bit per cycle) and two degree updates on the single read port of the
// degree memory; self-loops are dropped in the front and never reach it
// after reset every address of the degree memory is swept to zero with
// edge_stall high
// a two-entry queue lets the front keep taking edges while results stall, until it fills
module edge_degree_grid_binner_top #(
	parameter int VERTEX_BITS = edgb_pkg::VERTEX_BITS_DEF,
	parameter int DEGREE_BITS = edgb_pkg::DEGREE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              width_we,
	input  logic [edgb_pkg::WIDTH_BITS-1:0]   width_data,
	input  logic                              edge_valid,
	output logic                              edge_stall,
	input  logic [VERTEX_BITS-1:0]            src_vertex,
	input  logic [VERTEX_BITS-1:0]            dst_vertex,
	output logic                              bin_valid,
	input  logic                              bin_stall,
	output logic [VERTEX_BITS-1:0]            cell_row,
	output logic [VERTEX_BITS-1:0]            cell_col,
	output logic [VERTEX_BITS-1:0]            local_first,
	output logic [VERTEX_BITS-1:0]            local_second,
	output logic [DEGREE_BITS-1:0]            first_degree,
	output logic [VERTEX_BITS-1:0]            highest_vertex,
	output logic [VERTEX_BITS:0]              cells_per_side,
	output logic                              last
);
	import edgb_pkg::*;

	localparam int EW = 3*VERTEX_BITS + 1;

	logic [WIDTH_BITS-1:0] width_q, eff_width;
	logic push, pop, q_empty, q_full, clr_busy;
	logic [EW-1:0] push_data, head;

	// a zero width acts as one
	assign eff_width = (width_q == '0) ? WIDTH_BITS'(1) : width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
		end else if (width_we) begin
			width_q <= width_data;
		end
	end

	edgb_front #(.VERTEX_BITS(VERTEX_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .edge_valid(edge_valid), .edge_stall(edge_stall),
		.src_vertex(src_vertex), .dst_vertex(dst_vertex), .queue_full(q_full),
		.clr_busy(clr_busy), .push(push), .push_data(push_data)
	);

	edgb_fifo #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.pop(pop), .head(head), .empty(q_empty), .full(q_full)
	);

	edgb_back #(.VERTEX_BITS(VERTEX_BITS), .DEGREE_BITS(DEGREE_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .eff_width(eff_width), .queue_empty(q_empty),
		.head(head), .pop(pop), .clr_busy(clr_busy), .bin_valid(bin_valid),
		.bin_stall(bin_stall), .cell_row(cell_row), .cell_col(cell_col),
		.local_first(local_first), .local_second(local_second),
		.first_degree(first_degree), .highest_vertex(highest_vertex),
		.cells_per_side(cells_per_side), .last(last)
	);
endmodule

// File: tb/sv/edge_degree_grid_binner_top_test.sv
// ----------------------------------------------------------------------------
// edge_degree_grid_binner_top_test
// Sends edges through the binner under random gaps and result stalls, keeps
// its own degree table, running maximum and grid count, and compares every
// binned edge field by field against the predicted ones, in order.
// ----------------------------------------------------------------------------
module edge_degree_grid_binner_top_test;
	import edgb_pkg::*;

	localparam int VB = VERTEX_BITS_DEF;
	localparam int DB = DEGREE_BITS_DEF;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int SETTLE_CYCLES = 200;

	typedef struct {
		logic [VB-1:0] row;
		logic [VB-1:0] col;
		logic [VB-1:0] loc_a;
		logic [VB-1:0] loc_b;
		logic [DB-1:0] deg_a;
		logic [VB-1:0] top_v;
		logic [VB:0]   cells;
		logic          is_rev;
	} bin_t;

	logic              clk;
	logic              arst_n;
	logic              width_we;
	logic [WIDTH_BITS-1:0] width_data;
	logic              edge_valid;
	logic              edge_stall;
	logic [VB-1:0]     src_vertex;
	logic [VB-1:0]     dst_vertex;
	logic              bin_valid;
	logic              bin_stall;
	logic [VB-1:0]     cell_row;
	logic [VB-1:0]     cell_col;
	logic [VB-1:0]     local_first;
	logic [VB-1:0]     local_second;
	logic [DB-1:0]     first_degree;
	logic [VB-1:0]     highest_vertex;
	logic [VB:0]       cells_per_side;
	logic              last;

	// predictor state
	logic [DB-1:0]     vertex_degree [0:(1<<VB)-1];
	logic [VB-1:0]     max_vertex;
	logic [VB:0]       grid_cells;
	logic [WIDTH_BITS-1:0] cell_width;

	bin_t              bins_pending[$];
	int                mismatches;
	int                cycles;
	bit                no_idle;
	int                holdoff_requests;
	int                holdoffs_done;
	int                holdoff_left;

	edge_degree_grid_binner_top DUT (
		.clk(clk), .arst_n(arst_n),
		.width_we(width_we), .width_data(width_data),
		.edge_valid(edge_valid), .edge_stall(edge_stall),
		.src_vertex(src_vertex), .dst_vertex(dst_vertex),
		.bin_valid(bin_valid), .bin_stall(bin_stall),
		.cell_row(cell_row), .cell_col(cell_col),
		.local_first(local_first), .local_second(local_second),
		.first_degree(first_degree), .highest_vertex(highest_vertex),
		.cells_per_side(cells_per_side), .last(last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bin_t make_bin(logic [VB-1:0] a, logic [VB-1:0] b, logic rev);
		bin_t r;
		int unsigned w;
		w = (cell_width == 0) ? 1 : cell_width;
		r.row = VB'(a / w);
		r.col = VB'(b / w);
		r.loc_a = VB'(a % w);
		r.loc_b = VB'(b % w);
		r.deg_a = vertex_degree[a];
		r.top_v = max_vertex;
		r.cells = grid_cells;
		r.is_rev = rev;
		return r;
	endfunction

	task automatic predict_bins(logic [VB-1:0] s, logic [VB-1:0] d);
		logic [VB-1:0] big;
		int unsigned cnt;
		int unsigned w;
		if (s == d)
			return;
		big = (s > d) ? s : d;
		if (big > max_vertex) begin
			max_vertex = big;
			w = (cell_width == 0) ? 1 : cell_width;
			cnt = max_vertex / w + 1;
			if (cnt > grid_cells)
				grid_cells = (VB+1)'(cnt);
		end
		if (vertex_degree[s] != '1)
			vertex_degree[s] = vertex_degree[s] + 1;
		if (vertex_degree[d] != '1)
			vertex_degree[d] = vertex_degree[d] + 1;
		bins_pending.insert(bins_pending.size(), make_bin(s, d, 1'b0));
		bins_pending.insert(bins_pending.size(), make_bin(d, s, 1'b1));
	endtask

	// one edge transfer; valid stays high on return so back-to-back edges need no drop
	task automatic send_edge(logic [VB-1:0] s, logic [VB-1:0] d);
		int gap;
		gap = 0;
		if (!no_idle && $urandom_range(99) < 34)
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			edge_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		edge_valid <= 1'b1;
		src_vertex <= s;
		dst_vertex <= d;
		do
			@(posedge clk);
		while (edge_stall);
		predict_bins(s, d);
	endtask

	task automatic wait_drained();
		edge_valid <= 1'b0;
		@(posedge clk);
		while (bins_pending.size() > 0)
			@(posedge clk);
	endtask

	// self-loops leave no result and are dropped in the front; wait after draining before the width changes
	task automatic write_width(logic [WIDTH_BITS-1:0] w);
		wait_drained();
		repeat (100) @(posedge clk);
		width_we <= 1'b1;
		width_data <= w;
		@(posedge clk);
		width_we <= 1'b0;
		cell_width = w;
	endtask

	task automatic send_random_edge();
		logic [VB-1:0] s;
		logic [VB-1:0] d;
		int pick;
		pick = $urandom_range(99);
		s = VB'($urandom);
		d = VB'($urandom);
		if (pick < 30) begin
			s = VB'($urandom_range(31));
			d = VB'($urandom_range(31));
		end else if (pick < 38) begin
			d = s;
		end else if (pick < 45) begin
			s = '1;
		end else if (pick < 50) begin
			d = '0;
		end
		send_edge(s, d);
	endtask

	task automatic test_directed();
		send_edge(16'd0, 16'd1);
		send_edge(16'd1, 16'd0);
		send_edge(16'd3, 16'd3);
		send_edge(16'd0, 16'd0);
		send_edge(16'd2, 16'd3);
		write_width(17'd0);
		send_edge(16'd4, 16'd5);
		send_edge(16'd5, 16'd4);
		write_width(17'd65536);
		send_edge(16'd10, 16'd200);
		write_width(17'd7);
		send_edge(16'd100, 16'd50);
		send_edge(16'd99, 16'd6);
		write_width(17'h1FFFF);
		send_edge(16'd1000, 16'd7);
		write_width(17'd1);
		send_edge(16'd0, 16'hFFFF);
		send_edge(16'hFFFF, 16'd0);
		send_edge(16'hFFFF, 16'hFFFF);
		send_edge(16'hAAAA, 16'h5555);
		send_edge(16'h5555, 16'hAAAA);
		repeat (4) send_edge(16'd7, 16'd8);
	endtask

	task automatic test_random_widths();
		logic [WIDTH_BITS-1:0] widths [8];
		widths = '{17'd1, 17'd2, 17'd1024, 17'd65535, 17'd65536, 17'h1FFFF, 17'd0, 17'd13};
		for (int p = 0; p < 8; p++) begin
			write_width((p == 7) ? WIDTH_BITS'($urandom) : widths[p]);
			no_idle = (p == 3);
			repeat (160) send_random_edge();
		end
		no_idle = 1'b0;
	endtask

	task automatic test_result_holdoff();
		holdoff_requests++;
		repeat (30) send_random_edge();
		edge_valid <= 1'b0;
		while (holdoffs_done < holdoff_requests)
			@(posedge clk);
	endtask

	task automatic test_sender_pause();
		repeat (20) send_random_edge();
		wait_drained();
		repeat (150) send_random_edge();
	endtask

	// result side: random stalls, one long hold-off on request, and the check
	always @(posedge clk) begin
		bin_t e;
		if (bin_valid && !bin_stall) begin
			if (bins_pending.size() == 0) begin
				$error("unexpected bin: row %0d col %0d", cell_row, cell_col);
				mismatches++;
			end else begin
				e = bins_pending.pop_front();
				if (cell_row !== e.row) begin
					$error("cell_row exp %0d got %0d", e.row, cell_row); mismatches++;
				end
				if (cell_col !== e.col) begin
					$error("cell_col exp %0d got %0d", e.col, cell_col); mismatches++;
				end
				if (local_first !== e.loc_a) begin
					$error("local_first exp %0d got %0d", e.loc_a, local_first); mismatches++;
				end
				if (local_second !== e.loc_b) begin
					$error("local_second exp %0d got %0d", e.loc_b, local_second); mismatches++;
				end
				if (first_degree !== e.deg_a) begin
					$error("first_degree exp %0d got %0d", e.deg_a, first_degree); mismatches++;
				end
				if (highest_vertex !== e.top_v) begin
					$error("highest_vertex exp %0d got %0d", e.top_v, highest_vertex);
					mismatches++;
				end
				if (cells_per_side !== e.cells) begin
					$error("cells_per_side exp %0d got %0d", e.cells, cells_per_side);
					mismatches++;
				end
				if (last !== e.is_rev) begin
					$error("last exp %0d got %0d", e.is_rev, last); mismatches++;
				end
			end
		end
		if (holdoff_left > 0) begin
			bin_stall <= 1'b1;
			holdoff_left <= holdoff_left - 1;
			if (holdoff_left == 1)
				holdoffs_done <= holdoffs_done + 1;
		end else if (holdoffs_done < holdoff_requests) begin
			bin_stall <= 1'b1;
			holdoff_left <= 600;
		end else begin
			bin_stall <= !no_idle && ($urandom_range(99) < 34);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("edge_degree_grid_binner_top_test failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		width_we = 1'b0;
		width_data = '0;
		edge_valid = 1'b0;
		src_vertex = '0;
		dst_vertex = '0;
		bin_stall = 1'b0;
		mismatches = 0;
		cycles = 0;
		no_idle = 1'b0;
		holdoff_requests = 0;
		holdoffs_done = 0;
		holdoff_left = 0;
		for (int i = 0; i < (1 << VB); i++)
			vertex_degree[i] = '0;
		max_vertex = '0;
		grid_cells = '0;
		cell_width = WIDTH_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_widths();
		test_result_holdoff();
		test_sender_pause();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && bins_pending.size() == 0)
			$display("edge_degree_grid_binner_top_test passed");
		else
			$display("edge_degree_grid_binner_top_test failed");
		$finish;
	end

endmodule
